/* hw/rtl/tfl_pkg.sv */
package tfl_pkg;

  localparam int TAG_W     = 36;
  localparam int FRAME_W   = 20;
  localparam int OFF_W     = 12;
  localparam int LIDX_W    = 8;
  localparam int LINES_DEF = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic               fill;
    logic               write;
    logic               flush;
    logic               promote;
    logic [TAG_W-1:0]   tag;
    logic [FRAME_W-1:0] frame;
    logic               live;
    logic [LIDX_W-1:0]  line_sel;
  } cell_cmd_t;

endpackage

/* hw/rtl/tfl_cell.sv */
module tfl_cell import tfl_pkg::*; #(
  parameter int LINES = LINES_DEF,
  parameter int ID    = 0,
  parameter int RW    = $clog2(LINES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_cmd_t          cmd,
  input  logic [RW-1:0]      win_idx,
  input  logic [RW-1:0]      win_rank,
  input  logic               found_in,
  input  logic [RW-1:0]      rank_in,
  input  logic [RW-1:0]      idx_in,
  input  logic [FRAME_W-1:0] frame_in,
  output logic               found_out,
  output logic [RW-1:0]      rank_out,
  output logic [RW-1:0]      idx_out,
  output logic [FRAME_W-1:0] frame_out
);

  localparam logic [RW-1:0]     MY_IDX  = RW'(ID);
  localparam logic [LIDX_W-1:0] MY_LIDX = LIDX_W'(ID);
  localparam logic [RW-1:0]     TOP     = RW'(LINES - 1);

  logic [TAG_W-1:0]   tag_r;
  logic [FRAME_W-1:0] frame_r;
  logic               live_r;
  logic [RW-1:0]      rank_r;
  logic               found_r;
  logic [RW-1:0]      crank_r;
  logic [RW-1:0]      cidx_r;
  logic [FRAME_W-1:0] cframe_r;
  logic               take;

  assign take = live_r && (tag_r == cmd.tag) && (!found_in || rank_r > rank_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= 1'b0;
      rank_r  <= MY_IDX;
      found_r <= 1'b0;
    end else begin
      found_r <= found_in || take;
      if (cmd.fill) begin
        if (rank_r == '0) begin
          tag_r   <= cmd.tag;
          frame_r <= cmd.frame;
          live_r  <= 1'b1;
          rank_r  <= TOP;
        end else begin
          rank_r <= rank_r - RW'(1);
        end
      end
      if (cmd.write && cmd.line_sel == MY_LIDX) begin
        tag_r   <= cmd.tag;
        frame_r <= cmd.frame;
        live_r  <= cmd.live;
      end
      if (cmd.flush) begin
        live_r <= 1'b0;
      end
      if (cmd.promote) begin
        if (win_idx == MY_IDX) begin
          rank_r <= TOP;
        end else if (rank_r > win_rank) begin
          rank_r <= rank_r - RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    crank_r  <= take ? rank_r : rank_in;
    cidx_r   <= take ? MY_IDX : idx_in;
    cframe_r <= take ? frame_r : frame_in;
  end

  assign found_out = found_r;
  assign rank_out  = crank_r;
  assign idx_out   = cidx_r;
  assign frame_out = cframe_r;

endmodule

/* hw/rtl/tlb_fully_assoc_lru_unit.sv */
// Fully associative TLB, LINES lines, exact LRU order.
// Input: an item is transferred at a clock edge with start high and busy low.
// Operations: lookup, fill (overwrites the least recent line), write line by
// index (order untouched, out-of-range index flagged in out_status), flush.
// Output: every item gives one result, shown for one cycle with out_valid high.
// The receiver cannot stall; results are never held.
// Lookup: the tag match result travels down the row of line cells, one cell
// per cycle, and out_valid rises through the output register after the last
// cell; the next item can be taken once the result is shown.
// Fill, write and flush: the item passes the execute state and then the
// output register; the next item can be taken once the result is shown.
// busy is high from the transfer until the cycle that shows the result.
// Reset (rst_n low, synchronous): all lines invalid, line i holds rank i,
// no result pending.
module tlb_fully_assoc_lru_unit import tfl_pkg::*; #(
  parameter int LINES = LINES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [TAG_W-1:0]   in_virtual_page,
  input  logic [OFF_W-1:0]   in_offset_in,
  input  logic [FRAME_W-1:0] in_fill_phys_page,
  input  logic [LIDX_W-1:0]  in_line_sel,
  input  logic               in_entry_valid,
  output logic               out_valid,
  output logic               out_hit,
  output logic [FRAME_W-1:0] out_phys_page,
  output logic [OFF_W-1:0]   out_offset_out,
  output logic               out_status
);

  localparam int RW = $clog2(LINES);
  localparam int CW = $clog2(LINES + 1);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  op_t                op_r;
  logic [TAG_W-1:0]   vpage_r;
  logic [OFF_W-1:0]   off_r;
  logic [FRAME_W-1:0] frame_r;
  logic [LIDX_W-1:0]  lidx_r;
  logic               live_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [FRAME_W-1:0] out_page_r, out_page_nxt;
  logic [OFF_W-1:0]   out_off_r, out_off_nxt;
  logic               out_status_r, out_status_nxt;
  logic               accept;
  logic               scan_done;
  logic               in_range;
  cell_cmd_t          cmd;

  logic               found_c [0:LINES];
  logic [RW-1:0]      rank_c  [0:LINES];
  logic [RW-1:0]      idx_c   [0:LINES];
  logic [FRAME_W-1:0] frame_c [0:LINES];

  assign accept    = start && !busy;
  assign scan_done = (state_r == S_SCAN) && (cnt_r == CW'(LINES));
  assign in_range  = {1'b0, lidx_r} < (LIDX_W + 1)'(LINES);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (op_t'(in_operation) == OP_LOOKUP) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state_r != S_IDLE);
    cnt_nxt        = (state_r == S_SCAN) ? cnt_r + CW'(1) : '0;
    cmd.fill       = (state_r == S_EXEC) && (op_r == OP_FILL);
    cmd.write      = (state_r == S_EXEC) && (op_r == OP_WRITE) && in_range;
    cmd.flush      = (state_r == S_EXEC) && (op_r == OP_FLUSH);
    cmd.promote    = scan_done && found_c[LINES];
    cmd.tag        = vpage_r;
    cmd.frame      = frame_r;
    cmd.live       = live_r;
    cmd.line_sel   = lidx_r;
    out_valid_nxt  = scan_done || (state_r == S_EXEC);
    out_hit_nxt    = scan_done && found_c[LINES];
    out_page_nxt   = out_hit_nxt ? frame_c[LINES] : '0;
    out_off_nxt    = out_hit_nxt ? off_r : '0;
    out_status_nxt = (state_r == S_EXEC) && (op_r == OP_WRITE) && !in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_operation);
      vpage_r <= in_virtual_page;
      off_r   <= in_offset_in;
      frame_r <= in_fill_phys_page;
      lidx_r  <= in_line_sel;
      live_r  <= in_entry_valid;
    end
    out_hit_r    <= out_hit_nxt;
    out_page_r   <= out_page_nxt;
    out_off_r    <= out_off_nxt;
    out_status_r <= out_status_nxt;
  end

  assign found_c[0] = 1'b0;
  assign rank_c[0]  = '0;
  assign idx_c[0]   = '0;
  assign frame_c[0] = '0;

  for (genvar i = 0; i < LINES; i++) begin : g_cell
    tfl_cell #(
      .LINES(LINES),
      .ID   (i),
      .RW   (RW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .win_idx  (idx_c[LINES]),
      .win_rank (rank_c[LINES]),
      .found_in (found_c[i]),
      .rank_in  (rank_c[i]),
      .idx_in   (idx_c[i]),
      .frame_in (frame_c[i]),
      .found_out(found_c[i+1]),
      .rank_out (rank_c[i+1]),
      .idx_out  (idx_c[i+1]),
      .frame_out(frame_c[i+1])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_phys_page  = out_page_r;
  assign out_offset_out = out_off_r;
  assign out_status     = out_status_r;

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in progress");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_status)
    else $error("hit with error status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_phys_page == '0 && out_offset_out == '0)
    else $error("miss with nonzero payload");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transfer did not raise busy");

endmodule
